/* sv/mini_6502_bus_master_core_defines.svh */
// assertion macros shared by the bus master checker
`ifndef MINI_6502_BUS_MASTER_CORE_DEFINES_SVH
`define MINI_6502_BUS_MASTER_CORE_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define M6502BM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define M6502BM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/m6502bm_pkg.sv */
// types, codes and helpers for the reduced 6502 bus master
`default_nettype none

package m6502bm_pkg;

  typedef enum logic [2:0] {
    KIND_STEP  = 3'd0,
    KIND_REPLY = 3'd1,
    KIND_NMI   = 3'd2,
    KIND_IRQ   = 3'd3,
    KIND_RESET = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RST_LO  = 4'd1,
    PH_RST_HI  = 4'd2,
    PH_INT_PCH = 4'd3,
    PH_INT_PCL = 4'd4,
    PH_INT_P   = 4'd5,
    PH_INT_VLO = 4'd6,
    PH_INT_VHI = 4'd7,
    PH_FETCH   = 4'd8,
    PH_OPER1   = 4'd9,
    PH_OPER2   = 4'd10,
    PH_ZP_RD   = 4'd11,
    PH_STA_WR  = 4'd12
  } phase_t;

  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_TAX     = 8'hAA;
  localparam logic [7:0] OP_INX     = 8'hE8;

  localparam logic [7:0] FL_N = 8'h80;
  localparam logic [7:0] FL_U = 8'h20;
  localparam logic [7:0] FL_B = 8'h10;
  localparam logic [7:0] FL_I = 8'h04;
  localparam logic [7:0] FL_Z = 8'h02;

  localparam logic [15:0] RESET_VEC_LO = 16'hFFFC;
  localparam logic [15:0] RESET_VEC_HI = 16'hFFFD;
  localparam logic [7:0]  NMI_VEC_LO   = 8'hFA;
  localparam logic [7:0]  IRQ_VEC_LO   = 8'hFE;
  localparam logic [7:0]  VEC_PAGE     = 8'hFF;
  localparam logic [7:0]  STACK_PAGE   = 8'h01;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic        access_valid;
    logic        access_write;
    logic [15:0] access_address;
    logic [7:0]  access_data;
    logic        step_done;
    logic [7:0]  acc_value;
    logic [7:0]  index_value;
    logic [7:0]  stack_value;
    logic [7:0]  flags_value;
    logic [15:0] pc_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [15:0] pc;
    logic        nmi_pend;
    logic        irq_pend;
    phase_t      phase;
    logic [7:0]  opcode;
    logic [7:0]  oper_lo;
  } cpu_state_t;

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] f;
    f = p & ~(FL_N | FL_Z);
    if (v == 8'h00) f = f | FL_Z;
    f = f | (v & FL_N);
    return f;
  endfunction

endpackage

`default_nettype wire

/* sv/m6502bm_exec.sv */
// next-state and bus access logic for one item
`default_nettype none

module m6502bm_exec (
  input  m6502bm_pkg::cpu_state_t state,
  input  m6502bm_pkg::in_item_t    item,
  output m6502bm_pkg::cpu_state_t state_next,
  output m6502bm_pkg::out_item_t   result,
  output logic                     emit
);

  logic        acc_v;
  logic        acc_w;
  logic [15:0] acc_addr;
  logic [7:0]  acc_data;
  logic        done;
  logic [7:0]  d;

  assign d = item.read_data;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    acc_v      = 1'b0;
    acc_w      = 1'b0;
    acc_addr   = 16'h0000;
    acc_data   = 8'h00;
    done       = 1'b0;
    case (item.kind)
      m6502bm_pkg::KIND_STEP: begin
        if (state.phase == m6502bm_pkg::PH_IDLE) begin
          emit  = 1'b1;
          acc_v = 1'b1;
          if (state.nmi_pend || (state.irq_pend && ((state.p & m6502bm_pkg::FL_I) == 8'h00))) begin
            // interrupt entry: push pc high first
            if (state.nmi_pend) begin
              state_next.nmi_pend = 1'b0;
              state_next.opcode   = m6502bm_pkg::NMI_VEC_LO;
            end else begin
              state_next.irq_pend = 1'b0;
              state_next.opcode   = m6502bm_pkg::IRQ_VEC_LO;
            end
            acc_w            = 1'b1;
            acc_addr         = {m6502bm_pkg::STACK_PAGE, state.sp};
            acc_data         = state.pc[15:8];
            state_next.sp    = state.sp - 8'd1;
            state_next.phase = m6502bm_pkg::PH_INT_PCH;
          end else begin
            acc_addr         = state.pc;
            state_next.pc    = state.pc + 16'd1;
            state_next.phase = m6502bm_pkg::PH_FETCH;
          end
        end
      end
      m6502bm_pkg::KIND_REPLY: begin
        emit = 1'b1;
        case (state.phase)
          m6502bm_pkg::PH_RST_LO: begin
            state_next.oper_lo = d;
            acc_v              = 1'b1;
            acc_addr           = m6502bm_pkg::RESET_VEC_HI;
            state_next.phase   = m6502bm_pkg::PH_RST_HI;
          end
          m6502bm_pkg::PH_RST_HI: begin
            state_next.pc       = {d, state.oper_lo};
            state_next.sp       = state.sp - 8'd3;
            state_next.p        = state.p | m6502bm_pkg::FL_U;
            state_next.nmi_pend = 1'b0;
            state_next.irq_pend = 1'b0;
            done                = 1'b1;
            state_next.phase    = m6502bm_pkg::PH_IDLE;
          end
          m6502bm_pkg::PH_INT_PCH: begin
            acc_v            = 1'b1;
            acc_w            = 1'b1;
            acc_addr         = {m6502bm_pkg::STACK_PAGE, state.sp};
            acc_data         = state.pc[7:0];
            state_next.sp    = state.sp - 8'd1;
            state_next.phase = m6502bm_pkg::PH_INT_PCL;
          end
          m6502bm_pkg::PH_INT_PCL: begin
            acc_v            = 1'b1;
            acc_w            = 1'b1;
            acc_addr         = {m6502bm_pkg::STACK_PAGE, state.sp};
            acc_data         = state.p & ~m6502bm_pkg::FL_B;
            state_next.sp    = state.sp - 8'd1;
            state_next.phase = m6502bm_pkg::PH_INT_P;
          end
          m6502bm_pkg::PH_INT_P: begin
            state_next.p     = state.p | m6502bm_pkg::FL_I;
            acc_v            = 1'b1;
            acc_addr         = {m6502bm_pkg::VEC_PAGE, state.opcode};
            state_next.phase = m6502bm_pkg::PH_INT_VLO;
          end
          m6502bm_pkg::PH_INT_VLO: begin
            state_next.oper_lo = d;
            acc_v              = 1'b1;
            acc_addr           = {m6502bm_pkg::VEC_PAGE, state.opcode + 8'd1};
            state_next.phase   = m6502bm_pkg::PH_INT_VHI;
          end
          m6502bm_pkg::PH_INT_VHI: begin
            state_next.pc    = {d, state.oper_lo};
            done             = 1'b1;
            state_next.phase = m6502bm_pkg::PH_IDLE;
          end
          m6502bm_pkg::PH_FETCH: begin
            state_next.opcode = d;
            if (d inside {m6502bm_pkg::OP_LDA_IMM, m6502bm_pkg::OP_LDA_ZP,
                          m6502bm_pkg::OP_STA_ABS}) begin
              acc_v            = 1'b1;
              acc_addr         = state.pc;
              state_next.pc    = state.pc + 16'd1;
              state_next.phase = m6502bm_pkg::PH_OPER1;
            end else begin
              if (d == m6502bm_pkg::OP_TAX) begin
                state_next.x = state.a;
                state_next.p = m6502bm_pkg::set_nz(state.p, state.a);
              end else if (d == m6502bm_pkg::OP_INX) begin
                state_next.x = state.x + 8'd1;
                state_next.p = m6502bm_pkg::set_nz(state.p, state.x + 8'd1);
              end
              done             = 1'b1;
              state_next.phase = m6502bm_pkg::PH_IDLE;
            end
          end
          m6502bm_pkg::PH_OPER1: begin
            if (state.opcode == m6502bm_pkg::OP_LDA_IMM) begin
              state_next.a     = d;
              state_next.p     = m6502bm_pkg::set_nz(state.p, d);
              done             = 1'b1;
              state_next.phase = m6502bm_pkg::PH_IDLE;
            end else if (state.opcode == m6502bm_pkg::OP_LDA_ZP) begin
              acc_v            = 1'b1;
              acc_addr         = {8'h00, d};
              state_next.phase = m6502bm_pkg::PH_ZP_RD;
            end else begin
              state_next.oper_lo = d;
              acc_v              = 1'b1;
              acc_addr           = state.pc;
              state_next.pc      = state.pc + 16'd1;
              state_next.phase   = m6502bm_pkg::PH_OPER2;
            end
          end
          m6502bm_pkg::PH_OPER2: begin
            acc_v            = 1'b1;
            acc_w            = 1'b1;
            acc_addr         = {d, state.oper_lo};
            acc_data         = state.a;
            state_next.phase = m6502bm_pkg::PH_STA_WR;
          end
          m6502bm_pkg::PH_ZP_RD: begin
            state_next.a     = d;
            state_next.p     = m6502bm_pkg::set_nz(state.p, d);
            done             = 1'b1;
            state_next.phase = m6502bm_pkg::PH_IDLE;
          end
          m6502bm_pkg::PH_STA_WR: begin
            done             = 1'b1;
            state_next.phase = m6502bm_pkg::PH_IDLE;
          end
          default: begin
            // reply with nothing outstanding
            emit = 1'b0;
          end
        endcase
      end
      m6502bm_pkg::KIND_NMI: begin
        state_next.nmi_pend = 1'b1;
      end
      m6502bm_pkg::KIND_IRQ: begin
        state_next.irq_pend = 1'b1;
      end
      m6502bm_pkg::KIND_RESET: begin
        emit             = 1'b1;
        acc_v            = 1'b1;
        acc_addr         = m6502bm_pkg::RESET_VEC_LO;
        state_next.phase = m6502bm_pkg::PH_RST_LO;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    result.access_valid   = acc_v;
    result.access_write   = acc_w;
    result.access_address = acc_addr;
    result.access_data    = acc_data;
    result.step_done      = done;
    result.acc_value      = state_next.a;
    result.index_value    = state_next.x;
    result.stack_value    = state_next.sp;
    result.flags_value    = state_next.p;
    result.pc_value       = state_next.pc;
  end

endmodule

`default_nettype wire

/* sv/mini_6502_bus_master_core.sv */
// top level of the reduced 6502 bus master
//
//   channel   direction   handshake                   payload
//   item      in          item_valid / item_ready     m6502bm_pkg::in_item_t
//   result    out         result_valid / result_ready m6502bm_pkg::out_item_t
//
// one item per cycle unless the result stalls; an item passes an input register,
// then the execute logic updates the cpu registers and loads the result register
// items that produce no result (requests, ignored steps or replies) still take
// their slot in the input register but never reach the result side
// a stalled result holds the execute stage; the input register still takes one item
// rst is synchronous and clears the cpu registers, pending flags and both valids
`default_nettype none

module mini_6502_bus_master_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  m6502bm_pkg::in_item_t   item,
  output logic                    result_valid,
  input  logic                    result_ready,
  output m6502bm_pkg::out_item_t  result
);

  m6502bm_pkg::in_item_t    item_q;
  logic                     item_q_valid;
  m6502bm_pkg::cpu_state_t  state;
  m6502bm_pkg::cpu_state_t  state_next;
  m6502bm_pkg::out_item_t   result_next;
  logic                     emit;
  logic                     exec_fire;

  assign exec_fire  = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || exec_fire;

  m6502bm_exec u_exec (
    .state      (state),
    .item       (item_q),
    .state_next (state_next),
    .result     (result_next),
    .emit       (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.a        <= 8'h00;
      state.x        <= 8'h00;
      state.sp       <= 8'h00;
      state.p        <= 8'h00;
      state.pc       <= 16'h0000;
      state.nmi_pend <= 1'b0;
      state.irq_pend <= 1'b0;
      state.phase    <= m6502bm_pkg::PH_IDLE;
      state.opcode   <= 8'h00;
      state.oper_lo  <= 8'h00;
    end else if (exec_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (exec_fire) begin
      result_valid <= emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (exec_fire && emit) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

/* sv/m6502bm_checker.sv */
// port-level checks for the bus master, bound to the top level
`default_nettype none
`include "mini_6502_bus_master_core_defines.svh"

module m6502bm_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_ready,
  input m6502bm_pkg::in_item_t  item,
  input logic                   result_valid,
  input logic                   result_ready,
  input m6502bm_pkg::out_item_t result
);

  logic stalled;
  logic in_stall;
  logic no_access;
  logic bus_clear;
  logic finishing;

  assign stalled   = result_valid && !result_ready;
  assign in_stall  = item_valid && !item_ready;
  assign no_access = result_valid && !result.access_valid;
  assign bus_clear = !result.access_write && result.access_address == 16'h0000 &&
                     result.access_data == 8'h00;
  assign finishing = result_valid && result.step_done;

  `M6502BM_ASSERT_NEXT(a_hold, clk, rst, stalled, result_valid && $stable(result), "result moved")
  `M6502BM_ASSERT_NEXT(a_in_hold, clk, rst, in_stall, item_valid && $stable(item), "item moved")
  // the input side only blocks behind a stalled result
  `M6502BM_ASSERT_SAME(a_ready, clk, rst, !item_ready, stalled, "input blocked")
  `M6502BM_ASSERT_SAME(a_idle_bus, clk, rst, no_access, bus_clear, "bus fields set")
  `M6502BM_ASSERT_SAME(a_done_bus, clk, rst, finishing, !result.access_valid, "access on finish")

endmodule

bind mini_6502_bus_master_core m6502bm_checker u_checker (.*);

`default_nettype wire

/* tb/sv/mini_6502_bus_master_core_tb.sv */
// self-checking testbench for the reduced 6502 bus master core
module mini_6502_bus_master_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import m6502bm_pkg::*;

  localparam int ITEM_TARGET  = 550;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int STEADY_FIRST = 200;
  localparam int STEADY_LAST  = 280;

  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
  localparam logic [7:0] OP_NOP_ANY       = 8'hEA;
  localparam logic [7:0] ZERO_PAGE        = 8'h00;

  typedef struct {
    in_item_t  stim;
    bit        fixed;
    out_item_t want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  bus_item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t bus_result;

  cpu_state_t shadow;
  out_item_t  predicted_bus_results[$];
  plan_row_t  plan[$];

  int  cycle_count = 0;
  int  items_accepted = 0;
  int  results_predicted = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  nmi_entries = 0;
  int  irq_entries = 0;
  bit  steady_run = 1'b0;

  mini_6502_bus_master_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (bus_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (bus_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic in_item_t mk_item(logic [2:0] kind, logic [7:0] data);
    in_item_t it;
    it.kind = kind;
    it.read_data = data;
    return it;
  endfunction

  // ---------------- cpu shadow ----------------

  function automatic logic [7:0] with_nz(logic [7:0] flags, logic [7:0] v);
    return (flags & ~(FL_N | FL_Z)) | ((v == 8'h00) ? FL_Z : 8'h00) | (v & FL_N);
  endfunction

  function automatic out_item_t snapshot(logic vld, logic wr, logic [15:0] addr,
                                         logic [7:0] data, logic done);
    out_item_t r;
    r.access_valid   = vld;
    r.access_write   = wr;
    r.access_address = addr;
    r.access_data    = data;
    r.step_done      = done;
    r.acc_value      = shadow.a;
    r.index_value    = shadow.x;
    r.stack_value    = shadow.sp;
    r.flags_value    = shadow.p;
    r.pc_value       = shadow.pc;
    return r;
  endfunction

  function automatic out_item_t bus_read(logic [15:0] addr, phase_t next);
    shadow.phase = next;
    return snapshot(1'b1, 1'b0, addr, 8'h00, 1'b0);
  endfunction

  function automatic out_item_t stack_push(logic [7:0] val, phase_t next);
    logic [15:0] addr;
    addr = {STACK_PAGE, shadow.sp};
    shadow.sp = shadow.sp - 8'd1;
    shadow.phase = next;
    return snapshot(1'b1, 1'b1, addr, val, 1'b0);
  endfunction

  function automatic out_item_t pc_fetch(phase_t next);
    logic [15:0] addr;
    addr = shadow.pc;
    shadow.pc = shadow.pc + 16'd1;
    return bus_read(addr, next);
  endfunction

  function automatic out_item_t seq_done();
    shadow.phase = PH_IDLE;
    return snapshot(1'b0, 1'b0, 16'h0000, 8'h00, 1'b1);
  endfunction

  // returns 1 when the item produces a result, which goes to res
  function automatic bit advance_cpu_shadow(in_item_t it, output out_item_t res);
    logic [7:0] d;
    logic [7:0] vec_next;
    d = it.read_data;
    res = '0;
    case (it.kind)
      KIND_STEP: begin
        if (shadow.phase != PH_IDLE) return 1'b0;
        if (shadow.nmi_pend) begin
          shadow.nmi_pend = 1'b0;
          shadow.opcode = NMI_VEC_LO;
          nmi_entries++;
          res = stack_push(shadow.pc[15:8], PH_INT_PCH);
        end else if (shadow.irq_pend && (shadow.p & FL_I) == 8'h00) begin
          shadow.irq_pend = 1'b0;
          shadow.opcode = IRQ_VEC_LO;
          irq_entries++;
          res = stack_push(shadow.pc[15:8], PH_INT_PCH);
        end else begin
          res = pc_fetch(PH_FETCH);
        end
        return 1'b1;
      end
      KIND_REPLY: begin
        case (shadow.phase)
          PH_RST_LO: begin
            shadow.oper_lo = d;
            res = bus_read(RESET_VEC_HI, PH_RST_HI);
          end
          PH_RST_HI: begin
            shadow.pc = {d, shadow.oper_lo};
            shadow.sp = shadow.sp - 8'd3;
            shadow.p = shadow.p | FL_U;
            shadow.nmi_pend = 1'b0;
            shadow.irq_pend = 1'b0;
            res = seq_done();
          end
          PH_INT_PCH: res = stack_push(shadow.pc[7:0], PH_INT_PCL);
          PH_INT_PCL: res = stack_push(shadow.p & ~FL_B, PH_INT_P);
          PH_INT_P: begin
            shadow.p = shadow.p | FL_I;
            res = bus_read({VEC_PAGE, shadow.opcode}, PH_INT_VLO);
          end
          PH_INT_VLO: begin
            shadow.oper_lo = d;
            vec_next = shadow.opcode + 8'd1;
            res = bus_read({VEC_PAGE, vec_next}, PH_INT_VHI);
          end
          PH_INT_VHI: begin
            shadow.pc = {d, shadow.oper_lo};
            res = seq_done();
          end
          PH_FETCH: begin
            shadow.opcode = d;
            case (d)
              OP_LDA_IMM, OP_LDA_ZP, OP_STA_ABS: res = pc_fetch(PH_OPER1);
              OP_TAX: begin
                shadow.x = shadow.a;
                shadow.p = with_nz(shadow.p, shadow.x);
                res = seq_done();
              end
              OP_INX: begin
                shadow.x = shadow.x + 8'd1;
                shadow.p = with_nz(shadow.p, shadow.x);
                res = seq_done();
              end
              default: res = seq_done();
            endcase
          end
          PH_OPER1: begin
            if (shadow.opcode == OP_LDA_IMM) begin
              shadow.a = d;
              shadow.p = with_nz(shadow.p, d);
              res = seq_done();
            end else if (shadow.opcode == OP_LDA_ZP) begin
              res = bus_read({ZERO_PAGE, d}, PH_ZP_RD);
            end else begin
              shadow.oper_lo = d;
              res = pc_fetch(PH_OPER2);
            end
          end
          PH_OPER2: begin
            shadow.phase = PH_STA_WR;
            res = snapshot(1'b1, 1'b1, {d, shadow.oper_lo}, shadow.a, 1'b0);
          end
          PH_ZP_RD: begin
            shadow.a = d;
            shadow.p = with_nz(shadow.p, d);
            res = seq_done();
          end
          PH_STA_WR: res = seq_done();
          default: return 1'b0;
        endcase
        return 1'b1;
      end
      KIND_NMI: begin
        shadow.nmi_pend = 1'b1;
        return 1'b0;
      end
      KIND_IRQ: begin
        shadow.irq_pend = 1'b1;
        return 1'b0;
      end
      KIND_RESET: begin
        res = bus_read(RESET_VEC_LO, PH_RST_LO);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------- stimulus ----------------

  // mostly well-formed step/reply traffic, with requests and out-of-turn items mixed in
  function automatic in_item_t next_random_item();
    in_item_t it;
    int roll;
    it.read_data = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 3) it.kind = KIND_NMI;
    else if (roll < 5) it.kind = KIND_IRQ;
    else if (roll < 7) it.kind = KIND_RESET;
    else if (roll < 9) it.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    else if (roll < 11) it.kind = (shadow.phase == PH_IDLE) ? KIND_REPLY : KIND_STEP;
    else begin
      it.kind = (shadow.phase == PH_IDLE) ? KIND_STEP : KIND_REPLY;
      if (shadow.phase == PH_FETCH && $urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 4))
          0: it.read_data = OP_LDA_IMM;
          1: it.read_data = OP_LDA_ZP;
          2: it.read_data = OP_STA_ABS;
          3: it.read_data = OP_TAX;
          default: it.read_data = OP_INX;
        endcase
      end
    end
    return it;
  endfunction

  task automatic offer_item(in_item_t it, bit fixed, out_item_t want);
    int gap;
    bit has_result;
    out_item_t predicted;
    gap = steady_run ? 0 : pick_gap();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bus_item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    items_accepted++;
    has_result = advance_cpu_shadow(it, predicted);
    if (has_result) begin
      predicted_bus_results.push_back(fixed ? want : predicted);
      results_predicted++;
    end
  endtask

  initial begin : stimulus
    plan_row_t r;
    // boot: reset vector fetch to ffff, then the first opcode fetch wraps pc
    plan.push_back('{mk_item(KIND_RESET, 8'h00), 1'b1,
      out_item_t'{1'b1, 1'b0, 16'hFFFC, 8'h00, 1'b0,
                  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}});
    plan.push_back('{mk_item(KIND_REPLY, 8'hFF), 1'b1,
      out_item_t'{1'b1, 1'b0, 16'hFFFD, 8'h00, 1'b0,
                  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000}});
    plan.push_back('{mk_item(KIND_REPLY, 8'hFF), 1'b1,
      out_item_t'{1'b0, 1'b0, 16'h0000, 8'h00, 1'b1,
                  8'h00, 8'h00, 8'hFD, 8'h20, 16'hFFFF}});
    plan.push_back('{mk_item(KIND_STEP, 8'h00), 1'b1,
      out_item_t'{1'b1, 1'b0, 16'hFFFF, 8'h00, 1'b0,
                  8'h00, 8'h00, 8'hFD, 8'h20, 16'h0000}});
    plan.push_back('{mk_item(KIND_REPLY, OP_LDA_IMM), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, 8'h00), 1'b0, '0});
    plan.push_back('{mk_item(KIND_STEP, 8'h00), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, OP_TAX), 1'b0, '0});
    plan.push_back('{mk_item(KIND_STEP, 8'h00), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, OP_INX), 1'b0, '0});
    // sta abs with a step thrown in while busy, ack data must be ignored
    plan.push_back('{mk_item(KIND_STEP, 8'h00), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, OP_STA_ABS), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, 8'h34), 1'b0, '0});
    plan.push_back('{mk_item(KIND_STEP, 8'hFF), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, 8'h12), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, 8'hA5), 1'b0, '0});
    plan.push_back('{mk_item(KIND_STEP, 8'h00), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, OP_LDA_ZP), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, 8'hFF), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, 8'h80), 1'b0, '0});
    plan.push_back('{mk_item(KIND_STEP, 8'h00), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, OP_NOP_ANY), 1'b0, '0});
    // reply while idle and a spare kind, both dropped
    plan.push_back('{mk_item(KIND_REPLY, 8'h55), 1'b0, '0});
    plan.push_back('{mk_item(KIND_SPARE_LAST, 8'hFF), 1'b0, '0});
    // irq entry while i is still clear; i stays set afterwards
    plan.push_back('{mk_item(KIND_IRQ, 8'h00), 1'b0, '0});
    plan.push_back('{mk_item(KIND_STEP, 8'h00), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, 8'h00), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, 8'h00), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, 8'h00), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, 8'h00), 1'b0, '0});
    plan.push_back('{mk_item(KIND_REPLY, 8'h80), 1'b0, '0});

    shadow = '0;
    shadow.phase = PH_IDLE;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      r = plan[i];
      offer_item(r.stim, r.fixed, r.want);
    end
    while (items_accepted < ITEM_TARGET) begin
      steady_run = (results_predicted >= STEADY_FIRST && results_predicted < STEADY_LAST);
      offer_item(next_random_item(), 1'b0, '0);
    end
    steady_run = 1'b0;
    item_valid <= 1'b0;

    while (predicted_bus_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items, %0d results checked, %0d nmi and %0d irq entries",
             items_accepted, results_seen, nmi_entries, irq_entries);
    $display("%0d mismatches, %0d results still awaited",
             mismatches, predicted_bus_results.size());
    if (mismatches == 0 && predicted_bus_results.size() == 0) begin
      $display("mini_6502_bus_master_core_tb: PASS");
    end else begin
      $display("mini_6502_bus_master_core_tb: FAIL");
    end
    $finish;
  end

  // ---------------- result side ----------------

  initial begin : result_sink
    int run;
    int stall;
    forever begin
      result_ready <= 1'b1;
      if (steady_run) begin
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 6);
        repeat (run) @(posedge clk);
        stall = pick_gap();
        if (stall != 0) begin
          result_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: result %0d %s expected %h got %h", $realtime, results_seen, fname,
               want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (predicted_bus_results.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none got %h", $realtime,
                 bus_result);
        mismatches++;
      end else begin
        want = predicted_bus_results.pop_front();
        check_field("access_valid", 16'(want.access_valid), 16'(bus_result.access_valid));
        check_field("access_write", 16'(want.access_write), 16'(bus_result.access_write));
        check_field("access_address", want.access_address, bus_result.access_address);
        check_field("access_data", 16'(want.access_data), 16'(bus_result.access_data));
        check_field("step_done", 16'(want.step_done), 16'(bus_result.step_done));
        check_field("acc_value", 16'(want.acc_value), 16'(bus_result.acc_value));
        check_field("index_value", 16'(want.index_value), 16'(bus_result.index_value));
        check_field("stack_value", 16'(want.stack_value), 16'(bus_result.stack_value));
        check_field("flags_value", 16'(want.flags_value), 16'(bus_result.flags_value));
        check_field("pc_value", want.pc_value, bus_result.pc_value);
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("mini_6502_bus_master_core_tb: FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/m6502bm_pkg.sv
sv/m6502bm_exec.sv
sv/mini_6502_bus_master_core.sv
sv/m6502bm_checker.sv
tb/sv/mini_6502_bus_master_core_tb.sv
